>>> rtl/gcsp_pkg.sv
// Shared types and constants for the GPU command stream parser.
// No dependencies; imported by the decoder and the top level.
package gcsp_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int COUNT_W     = 11;
    localparam int REG_IDX_W   = 15;
    localparam int COUNT_LSB   = 18;

    localparam logic [31:0] JUMP_ADDR_MASK = 32'h1fff_ffff;
    localparam logic [31:0] WORD_STEP      = 32'd4;

    localparam logic [31:0] JUMP_MASK_RST   = 32'h2000_0000;
    localparam logic [31:0] CALL_MASK_RST   = 32'h0000_0002;
    localparam logic [31:0] RETURN_WORD_RST = 32'h0002_0000;
    localparam logic [31:0] HOLD_MASK_RST   = 32'h4000_0000;

    typedef enum logic [1:0] {
        CFG_JUMP_MASK   = 2'd0,
        CFG_CALL_MASK   = 2'd1,
        CFG_RETURN_WORD = 2'd2,
        CFG_HOLD_MASK   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_NOP    = 3'd0,
        KIND_JUMP   = 3'd1,
        KIND_CALL   = 3'd2,
        KIND_RETURN = 3'd3,
        KIND_HEADER = 3'd4,
        KIND_DATA   = 3'd5
    } word_kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNDERFLOW = 2'd2
    } fault_t;

    typedef struct packed {
        logic [31:0] jump_mask;
        logic [31:0] call_mask;
        logic [31:0] return_word;
        logic [31:0] hold_mask;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   words_left;
        logic [REG_IDX_W-1:0] reg_ptr;
        logic                 hold_index;
        logic [LEVEL_W-1:0]   stack_level;
    } parse_state_t;

    typedef struct packed {
        logic [31:0]          next_offset;
        logic                 write_valid;
        logic [REG_IDX_W-1:0] reg_index;
        logic [31:0]          reg_value;
        word_kind_t           word_kind;
        fault_t               fault;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

endpackage

>>> rtl/gcsp_in_if.sv
// Input channel of the command stream parser: one fetched word and its offset.
// Depends on nothing.
interface gcsp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic [31:0] word_offset;

    modport source (output valid, output word, output word_offset, input ready);
    modport sink   (input valid, input word, input word_offset, output ready);
endinterface

>>> rtl/gcsp_out_if.sv
// Result channel of the command stream parser.
// Depends on nothing.
interface gcsp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_offset;
    logic        write_valid;
    logic [14:0] reg_index;
    logic [31:0] reg_value;
    logic [2:0]  word_kind;
    logic [1:0]  fault;

    modport source (output valid, output next_offset, output write_valid, output reg_index,
                    output reg_value, output word_kind, output fault, input ready);
    modport sink   (input valid, input next_offset, input write_valid, input reg_index,
                    input reg_value, input word_kind, input fault, output ready);
endinterface

>>> rtl/gcsp_decode.sv
// Combinational decode of one command word against the current parser state.
// Depends on gcsp_pkg.
module gcsp_decode
    import gcsp_pkg::*;
(
    input  logic [31:0]  word,
    input  logic [31:0]  word_offset,
    input  cfg_t         cfg,
    input  parse_state_t state,
    input  logic [31:0]  stack_top,
    output result_t      result,
    output parse_state_t state_next,
    output stack_op_t    stack_op
);

    logic [31:0] seq_offset;

    assign seq_offset = word_offset + WORD_STEP;

    always_comb
    begin
        result             = '0;
        result.next_offset = seq_offset;
        result.word_kind   = KIND_NOP;
        result.fault       = FAULT_NONE;
        state_next         = state;
        stack_op           = '0;

        if (state.words_left != '0)
        begin
            result.write_valid    = 1'b1;
            result.reg_index      = state.reg_ptr;
            result.reg_value      = word;
            result.word_kind      = KIND_DATA;
            if (!state.hold_index)
            begin
                state_next.reg_ptr = state.reg_ptr + REG_IDX_W'(1);
            end
            state_next.words_left = state.words_left - COUNT_W'(1);
        end
        else if ((word & cfg.jump_mask) != '0)
        begin
            result.word_kind   = KIND_JUMP;
            result.next_offset = word & JUMP_ADDR_MASK;
        end
        else if ((word & cfg.call_mask) != '0)
        begin
            result.word_kind   = KIND_CALL;
            result.next_offset = {word[31:2], 2'b00};
            if (state.stack_level < LEVEL_W'(STACK_DEPTH))
            begin
                stack_op.push          = 1'b1;
                state_next.stack_level = state.stack_level + LEVEL_W'(1);
            end
            else
            begin
                result.fault = FAULT_OVERFLOW;
            end
        end
        else if (word == cfg.return_word)
        begin
            result.word_kind = KIND_RETURN;
            if (state.stack_level != '0)
            begin
                stack_op.pop           = 1'b1;
                state_next.stack_level = state.stack_level - LEVEL_W'(1);
                result.next_offset     = stack_top;
            end
            else
            begin
                result.fault = FAULT_UNDERFLOW;
            end
        end
        else if (word != '0)
        begin
            result.word_kind      = KIND_HEADER;
            state_next.words_left = word[COUNT_LSB +: COUNT_W];
            state_next.reg_ptr    = {1'b0, word[15:2]};
            state_next.hold_index = (word & cfg.hold_mask) != '0;
        end
    end

endmodule

>>> rtl/gpu_command_stream_parser.sv
// Top level of the GPU command stream parser: input register, decode, result register.
// Depends on gcsp_pkg, gcsp_in_if, gcsp_out_if and gcsp_decode.
//
// Usage:
//   cmd carries one fetched command word and its byte offset per item; res
//   returns exactly one result per word: next fetch offset, word kind, an
//   optional method register write and a call stack fault code.
//   An accepted item passes through the input register into the result
//   register, where res.valid rises. One item is accepted every cycle
//   unless res stalls; the input register and the result register form a
//   two-stage pipeline, and parser state (pending data count, register
//   pointer, call stack) updates as an item moves into the result register.
//   When res stalls, the result register holds, then the input register
//   fills, and only then does cmd.ready drop.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes one register
//   per cycle and is meant to be used while the parser is idle.
//   Reset clears both pipeline stages, the parse state and the stack level
//   and loads the default configuration; call stack entries need no reset.
module gpu_command_stream_parser
    import gcsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    gcsp_in_if.sink           cmd,
    gcsp_out_if.source        res
);

    cfg_t         cfg_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         s1_valid_reg;
    logic [31:0]  s1_word_reg;
    logic [31:0]  s1_offset_reg;
    logic         res_valid_reg;
    result_t      res_reg;
    result_t      result;
    stack_op_t    stack_op;
    logic [31:0]  stack_mem [STACK_DEPTH];
    logic [31:0]  stack_top;
    logic [SP_W-1:0] pop_idx;
    logic         s1_advance;

    assign s1_advance = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jump_mask   <= JUMP_MASK_RST;
            cfg_reg.call_mask   <= CALL_MASK_RST;
            cfg_reg.return_word <= RETURN_WORD_RST;
            cfg_reg.hold_mask   <= HOLD_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_JUMP_MASK:   cfg_reg.jump_mask   <= cfg_data;
                CFG_CALL_MASK:   cfg_reg.call_mask   <= cfg_data;
                CFG_RETURN_WORD: cfg_reg.return_word <= cfg_data;
                CFG_HOLD_MASK:   cfg_reg.hold_mask   <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_word_reg   <= cmd.word;
            s1_offset_reg <= cmd.word_offset;
        end
    end

    assign pop_idx   = SP_W'(state_reg.stack_level - LEVEL_W'(1));
    assign stack_top = stack_mem[pop_idx];

    gcsp_decode u_decode (
        .word        (s1_word_reg),
        .word_offset (s1_offset_reg),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .stack_top   (stack_top),
        .result      (result),
        .state_next  (state_next),
        .stack_op    (stack_op)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && stack_op.push)
        begin
            stack_mem[state_reg.stack_level[SP_W-1:0]] <= s1_offset_reg + WORD_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_reg <= result;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.next_offset = res_reg.next_offset;
    assign res.write_valid = res_reg.write_valid;
    assign res.reg_index   = res_reg.reg_index;
    assign res.reg_value   = res_reg.reg_value;
    assign res.word_kind   = res_reg.word_kind;
    assign res.fault       = res_reg.fault;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stack_level <= LEVEL_W'(STACK_DEPTH))
        else $error("call stack level beyond depth");

    a_write_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.write_valid == (res_reg.word_kind == KIND_DATA)))
        else $error("write flag disagrees with word kind");

    a_fault_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.fault != FAULT_NONE) |->
        ((res_reg.fault == FAULT_OVERFLOW && res_reg.word_kind == KIND_CALL) ||
         (res_reg.fault == FAULT_UNDERFLOW && res_reg.word_kind == KIND_RETURN)))
        else $error("fault on wrong word kind");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_word_reg)))
        else $error("stalled input register lost its item");

    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(state_reg))
        else $error("parse state changed without an item");

endmodule
